[hw/rtl/bfcs_pkg.sv]
package bfcs_pkg;

   // image and window limits
   localparam int unsigned MAX_WIDTH  = 1024;
   localparam int unsigned MAX_WINDOW = 15;

   // field widths
   localparam int unsigned PIX_W   = 8;
   localparam int unsigned COL_W   = 10;
   localparam int unsigned ROW_W   = 12;
   localparam int unsigned IW_W    = 11;
   localparam int unsigned IH_W    = 12;
   localparam int unsigned WIN_W   = 4;
   localparam int unsigned CSR_W   = 12;
   localparam int unsigned CSR_AW  = 2;

   // running sums
   localparam int unsigned CS_W    = 12;
   localparam int unsigned WS_W    = 16;

   // reciprocal multiply
   localparam int unsigned RECIP_W     = 24;
   localparam int unsigned RECIP_SHIFT = 23;
   localparam int unsigned RECIP_ONE   = 1 << RECIP_SHIFT;
   localparam int unsigned PROD_W      = WS_W + RECIP_W;

   // row store: one row of MAX_WIDTH pixels per slot
   localparam int unsigned SLOT_W      = $clog2(MAX_WINDOW);
   localparam int unsigned STORE_DEPTH = MAX_WINDOW * MAX_WIDTH;
   localparam int unsigned STORE_AW    = SLOT_W + COL_W;

   // result queue
   localparam int unsigned RSP_DEPTH = 8;
   localparam int unsigned RSP_AW    = $clog2(RSP_DEPTH);
   localparam int unsigned RSP_CW    = $clog2(RSP_DEPTH + 1);

   // register indexes
   localparam logic [CSR_AW-1:0] CSR_WINDOW_WIDTH  = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_WINDOW_HEIGHT = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_IMAGE_WIDTH   = 2'd2;
   localparam logic [CSR_AW-1:0] CSR_IMAGE_HEIGHT  = 2'd3;

   // register reset values
   localparam logic [WIN_W-1:0] WINDOW_RESET = 4'd3;
   localparam logic [IW_W-1:0]  IMAGE_WIDTH_RESET  = 11'd640;
   localparam logic [IH_W-1:0]  IMAGE_HEIGHT_RESET = 12'd480;

   // (1<<23)/(m*n), index {m/2, n/2}
   localparam logic [RECIP_W-1:0] RECIP_TABLE [64] = '{
      RECIP_W'(RECIP_ONE / (1 * 1)),   RECIP_W'(RECIP_ONE / (1 * 3)),
      RECIP_W'(RECIP_ONE / (1 * 5)),   RECIP_W'(RECIP_ONE / (1 * 7)),
      RECIP_W'(RECIP_ONE / (1 * 9)),   RECIP_W'(RECIP_ONE / (1 * 11)),
      RECIP_W'(RECIP_ONE / (1 * 13)),  RECIP_W'(RECIP_ONE / (1 * 15)),
      RECIP_W'(RECIP_ONE / (3 * 1)),   RECIP_W'(RECIP_ONE / (3 * 3)),
      RECIP_W'(RECIP_ONE / (3 * 5)),   RECIP_W'(RECIP_ONE / (3 * 7)),
      RECIP_W'(RECIP_ONE / (3 * 9)),   RECIP_W'(RECIP_ONE / (3 * 11)),
      RECIP_W'(RECIP_ONE / (3 * 13)),  RECIP_W'(RECIP_ONE / (3 * 15)),
      RECIP_W'(RECIP_ONE / (5 * 1)),   RECIP_W'(RECIP_ONE / (5 * 3)),
      RECIP_W'(RECIP_ONE / (5 * 5)),   RECIP_W'(RECIP_ONE / (5 * 7)),
      RECIP_W'(RECIP_ONE / (5 * 9)),   RECIP_W'(RECIP_ONE / (5 * 11)),
      RECIP_W'(RECIP_ONE / (5 * 13)),  RECIP_W'(RECIP_ONE / (5 * 15)),
      RECIP_W'(RECIP_ONE / (7 * 1)),   RECIP_W'(RECIP_ONE / (7 * 3)),
      RECIP_W'(RECIP_ONE / (7 * 5)),   RECIP_W'(RECIP_ONE / (7 * 7)),
      RECIP_W'(RECIP_ONE / (7 * 9)),   RECIP_W'(RECIP_ONE / (7 * 11)),
      RECIP_W'(RECIP_ONE / (7 * 13)),  RECIP_W'(RECIP_ONE / (7 * 15)),
      RECIP_W'(RECIP_ONE / (9 * 1)),   RECIP_W'(RECIP_ONE / (9 * 3)),
      RECIP_W'(RECIP_ONE / (9 * 5)),   RECIP_W'(RECIP_ONE / (9 * 7)),
      RECIP_W'(RECIP_ONE / (9 * 9)),   RECIP_W'(RECIP_ONE / (9 * 11)),
      RECIP_W'(RECIP_ONE / (9 * 13)),  RECIP_W'(RECIP_ONE / (9 * 15)),
      RECIP_W'(RECIP_ONE / (11 * 1)),  RECIP_W'(RECIP_ONE / (11 * 3)),
      RECIP_W'(RECIP_ONE / (11 * 5)),  RECIP_W'(RECIP_ONE / (11 * 7)),
      RECIP_W'(RECIP_ONE / (11 * 9)),  RECIP_W'(RECIP_ONE / (11 * 11)),
      RECIP_W'(RECIP_ONE / (11 * 13)), RECIP_W'(RECIP_ONE / (11 * 15)),
      RECIP_W'(RECIP_ONE / (13 * 1)),  RECIP_W'(RECIP_ONE / (13 * 3)),
      RECIP_W'(RECIP_ONE / (13 * 5)),  RECIP_W'(RECIP_ONE / (13 * 7)),
      RECIP_W'(RECIP_ONE / (13 * 9)),  RECIP_W'(RECIP_ONE / (13 * 11)),
      RECIP_W'(RECIP_ONE / (13 * 13)), RECIP_W'(RECIP_ONE / (13 * 15)),
      RECIP_W'(RECIP_ONE / (15 * 1)),  RECIP_W'(RECIP_ONE / (15 * 3)),
      RECIP_W'(RECIP_ONE / (15 * 5)),  RECIP_W'(RECIP_ONE / (15 * 7)),
      RECIP_W'(RECIP_ONE / (15 * 9)),  RECIP_W'(RECIP_ONE / (15 * 11)),
      RECIP_W'(RECIP_ONE / (15 * 13)), RECIP_W'(RECIP_ONE / (15 * 15))
   };

   // one result as it sits in the queue
   typedef struct packed {
      logic [PIX_W-1:0] filtered_pixel;
      logic [COL_W-1:0] centre_x;
      logic [ROW_W-1:0] centre_y;
   } rsp_type;

endpackage

[hw/rtl/bfcs_ram.sv]
module bfcs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read at the address being written returns the old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/bfcs_rsp_queue.sv]
module bfcs_rsp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  bfcs_pkg::rsp_type         push_data,
   input  logic                      pop,
   output logic                      valid,
   output bfcs_pkg::rsp_type         head,
   output logic [bfcs_pkg::RSP_CW-1:0] count
);

   import bfcs_pkg::*;

   rsp_type           slot_ff [RSP_DEPTH];
   logic [RSP_AW-1:0] wr_ptr_ff;
   logic [RSP_AW-1:0] rd_ptr_ff;
   logic [RSP_CW-1:0] count_ff;
   logic [RSP_CW-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + RSP_CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - RSP_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + RSP_AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + RSP_AW'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign valid = (count_ff != '0);
   assign head  = slot_ff[rd_ptr_ff];
   assign count = count_ff;

endmodule

[hw/rtl/box_filter_column_sums.sv]
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+----------------------------------------
// request   | in        | req_valid / req_stall | req_pixel
// response  | out       | rsp_valid / rsp_stall | rsp_filtered_pixel, rsp_centre_x/_y
// csr       | in        | csr_write_en          | csr_index, csr_wdata
//
// one pixel per clock while req_stall is low; the column-sum memory is read the cycle a
// request is taken and written back the next, so the read/modify/write loop sets this rate
// the result of a completed window passes the multiply and product stages and the queue
// synchronous reset: registers to defaults, position to frame start; no clearing pass,
// column sums are overwritten on the first row of each frame
// results wait in an 8-entry queue; req_stall rises when queue plus in-flight stages could fill it
module box_filter_column_sums (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bfcs_pkg::PIX_W-1:0]    req_pixel,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bfcs_pkg::PIX_W-1:0]    rsp_filtered_pixel,
   output logic [bfcs_pkg::COL_W-1:0]    rsp_centre_x,
   output logic [bfcs_pkg::ROW_W-1:0]    rsp_centre_y,
   // register writes
   input  logic                          csr_write_en,
   input  logic [bfcs_pkg::CSR_AW-1:0]   csr_index,
   input  logic [bfcs_pkg::CSR_W-1:0]    csr_wdata
);

   import bfcs_pkg::*;

   // what a request carries from the read cycle into the update cycle
   typedef struct packed {
      logic [PIX_W-1:0]    pix;
      logic [COL_W-1:0]    col;
      logic [STORE_AW-1:0] waddr;
      logic                row_zero;   // first row of frame: overwrite column sum
      logic                sub_old;    // a full column is stored: drop the oldest pixel
      logic                col_zero;   // first column: restart the window sum
      logic                sub_left;   // a full window row: drop the leftmost column sum
      logic                emit;       // interior centre
      logic                fwd_cs;     // previous request hit the same column sum
      logic                fwd_px;     // previous request wrote the pixel read here
      logic [COL_W-1:0]    cx;
      logic [ROW_W-1:0]    cy;
   } stage1_type;

   // ---------------------------------------------------------------- registers
   logic [WIN_W-1:0] win_w_ff;
   logic [WIN_W-1:0] win_h_ff;
   logic [IW_W-1:0]  img_w_ff;
   logic [IH_W-1:0]  img_h_ff;
   logic [RECIP_W-1:0] recip_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_w_ff <= WINDOW_RESET;
         win_h_ff <= WINDOW_RESET;
         img_w_ff <= IMAGE_WIDTH_RESET;
         img_h_ff <= IMAGE_HEIGHT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_WINDOW_WIDTH:  win_w_ff <= csr_wdata[WIN_W-1:0];
            CSR_WINDOW_HEIGHT: win_h_ff <= csr_wdata[WIN_W-1:0];
            CSR_IMAGE_WIDTH:   img_w_ff <= csr_wdata[IW_W-1:0];
            CSR_IMAGE_HEIGHT:  img_h_ff <= csr_wdata[IH_W-1:0];
            default: ;
         endcase
      end
   end

   // effective window: odd, half size is the upper bits of the request
   logic [WIN_W-2:0] m_half;
   logic [WIN_W-2:0] n_half;
   logic [WIN_W-1:0] m_size;
   logic [WIN_W-1:0] n_size;

   assign m_half = win_w_ff[WIN_W-1:1];
   assign n_half = win_h_ff[WIN_W-1:1];
   assign m_size = {m_half, 1'b1};
   assign n_size = {n_half, 1'b1};

   // reciprocal is registered from the window registers and read by the multiply
   always_ff @(posedge clock) begin
      recip_ff <= RECIP_TABLE[{m_half, n_half}];
   end

   // effective image size
   logic [IW_W-1:0] w_eff;
   logic [IH_W-1:0] h_eff;

   always_comb begin
      if (img_w_ff == '0) begin
         w_eff = IW_W'(1);
      end else if (img_w_ff > IW_W'(MAX_WIDTH)) begin
         w_eff = IW_W'(MAX_WIDTH);
      end else begin
         w_eff = img_w_ff;
      end
      h_eff = (img_h_ff == '0) ? IH_W'(1) : img_h_ff;
   end

   // ---------------------------------------------------------------- stage 0: accept, read
   logic                req_take;
   logic [COL_W-1:0]    col_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [COL_W-1:0]    col_in;
   logic [ROW_W-1:0]    row_in;
   logic [SLOT_W-1:0]   slot_in;
   logic [SLOT_W:0]     old_slot_wide;
   logic [SLOT_W-1:0]   old_slot;
   logic [STORE_AW-1:0] store_raddr;
   logic [STORE_AW-1:0] store_waddr;
   logic                last_col;
   logic                last_row;
   stage1_type          s1_in;

   stage1_type          s1_ff;
   logic                s1_valid_ff;
   logic [RSP_CW-1:0]   q_count;
   logic [RSP_CW-1:0]   inflight;
   logic                s2_valid_ff;
   logic                s3_valid_ff;

   assign inflight  = RSP_CW'(s1_valid_ff) + RSP_CW'(s2_valid_ff) + RSP_CW'(s3_valid_ff);
   // credit check: every request in flight may still need a queue entry
   assign req_stall = (q_count + inflight) >= RSP_CW'(RSP_DEPTH);
   assign req_take  = req_valid && !req_stall;

   // slot of the row that leaves the window, modulo the store height
   always_comb begin
      if (slot_ff >= n_size) begin
         old_slot_wide = (SLOT_W + 1)'(slot_ff) - (SLOT_W + 1)'(n_size);
      end else begin
         old_slot_wide = (SLOT_W + 1)'(slot_ff) + (SLOT_W + 1)'(MAX_WINDOW)
                       - (SLOT_W + 1)'(n_size);
      end
      old_slot = old_slot_wide[SLOT_W-1:0];
   end

   assign store_raddr = {old_slot, col_ff};
   assign store_waddr = {slot_ff, col_ff};

   assign last_col = (IW_W'(col_ff) + IW_W'(1)) >= w_eff;
   assign last_row = ((ROW_W + 1)'(row_ff) + (ROW_W + 1)'(1)) >= (ROW_W + 1)'(h_eff);

   // raster position of the next pixel
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      if (last_col) begin
         col_in = '0;
         if (last_row) begin
            row_in  = '0;
            slot_in = '0;
         end else begin
            row_in  = row_ff + ROW_W'(1);
            slot_in = (slot_ff == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot_ff + SLOT_W'(1);
         end
      end else begin
         col_in = col_ff + COL_W'(1);
      end
   end

   always_comb begin
      s1_in.pix      = req_pixel;
      s1_in.col      = col_ff;
      s1_in.waddr    = store_waddr;
      s1_in.row_zero = (row_ff == '0);
      s1_in.sub_old  = row_ff >= ROW_W'(n_size);
      s1_in.col_zero = (col_ff == '0);
      s1_in.sub_left = col_ff >= COL_W'(m_size);
      s1_in.emit     = (row_ff >= ROW_W'({n_half, 1'b0})) &&
                       (col_ff >= COL_W'({m_half, 1'b0}));
      // the request now in the update stage writes back on this same edge
      s1_in.fwd_cs   = s1_valid_ff && (s1_ff.col == col_ff);
      s1_in.fwd_px   = s1_valid_ff && (s1_ff.waddr == store_raddr);
      s1_in.cx       = col_ff - COL_W'(m_half);
      s1_in.cy       = row_ff - ROW_W'(n_half);
   end

   // any register write restarts the frame
   always_ff @(posedge clock) begin
      if (reset || csr_write_en) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else if (req_take) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------------------------------------------------------- memories
   logic [CS_W-1:0]  cs_rdata;
   logic [PIX_W-1:0] px_rdata;
   logic [CS_W-1:0]  cs_new;

   bfcs_ram #(
      .WIDTH (CS_W),
      .DEPTH (MAX_WIDTH)
   ) u_column_sums (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_ff.col),
      .wr_data (cs_new),
      .rd_en   (req_take),
      .rd_addr (col_ff),
      .rd_data (cs_rdata)
   );

   bfcs_ram #(
      .WIDTH (PIX_W),
      .DEPTH (STORE_DEPTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_ff.waddr),
      .wr_data (s1_ff.pix),
      .rd_en   (req_take),
      .rd_addr (store_raddr),
      .rd_data (px_rdata)
   );

   // ---------------------------------------------------------------- stage 1: update
   logic [CS_W-1:0]  last_cs_ff;
   logic [PIX_W-1:0] last_px_ff;
   logic [CS_W-1:0]  cs_old;
   logic [PIX_W-1:0] px_old;
   logic [CS_W:0]    cs_sum;
   logic [CS_W-1:0]  hist_ff [MAX_WINDOW];
   logic [SLOT_W-1:0] left_tap;
   logic [WS_W-1:0]  ws_ff;
   logic [WS_W:0]    ws_sum;
   logic [WS_W-1:0]  ws_new;

   // bypass the memories when the previous request wrote the same entry
   assign cs_old = s1_ff.fwd_cs ? last_cs_ff : cs_rdata;
   assign px_old = s1_ff.fwd_px ? last_px_ff : px_rdata;

   always_comb begin
      cs_sum = (CS_W + 1)'(cs_old) + (CS_W + 1)'(s1_ff.pix);
      if (s1_ff.sub_old) begin
         cs_sum = cs_sum - (CS_W + 1)'(px_old);
      end
      cs_new = s1_ff.row_zero ? CS_W'(s1_ff.pix) : cs_sum[CS_W-1:0];
   end

   // hist_ff[k] holds the column sum k+1 columns to the left
   assign left_tap = SLOT_W'(m_size - WIN_W'(1));

   always_comb begin
      ws_sum = (WS_W + 1)'(ws_ff) + (WS_W + 1)'(cs_new);
      if (s1_ff.sub_left) begin
         ws_sum = ws_sum - (WS_W + 1)'(hist_ff[left_tap]);
      end
      ws_new = s1_ff.col_zero ? WS_W'(cs_new) : ws_sum[WS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff <= '0;
      end else if (s1_valid_ff) begin
         ws_ff <= ws_new;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         last_cs_ff <= cs_new;
         last_px_ff <= s1_ff.pix;
         hist_ff[0] <= cs_new;
         for (int k = 1; k < MAX_WINDOW; k++) begin
            hist_ff[k] <= hist_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------- stage 2: multiply
   logic [WS_W-1:0]  s2_ws_ff;
   logic [COL_W-1:0] s2_cx_ff;
   logic [ROW_W-1:0] s2_cy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff && s1_ff.emit;
      end
   end

   always_ff @(posedge clock) begin
      s2_ws_ff <= ws_new;
      s2_cx_ff <= s1_ff.cx;
      s2_cy_ff <= s1_ff.cy;
   end

   // ---------------------------------------------------------------- stage 3: product
   logic [PROD_W-1:0] s3_prod_ff;
   logic [COL_W-1:0]  s3_cx_ff;
   logic [ROW_W-1:0]  s3_cy_ff;
   rsp_type           q_push_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_prod_ff <= PROD_W'(s2_ws_ff) * PROD_W'(recip_ff);
      s3_cx_ff   <= s2_cx_ff;
      s3_cy_ff   <= s2_cy_ff;
   end

   always_comb begin
      q_push_data.filtered_pixel = s3_prod_ff[RECIP_SHIFT +: PIX_W];
      q_push_data.centre_x       = s3_cx_ff;
      q_push_data.centre_y       = s3_cy_ff;
   end

   // ---------------------------------------------------------------- result queue
   rsp_type q_head;
   logic    q_pop;

   assign q_pop = rsp_valid && !rsp_stall;

   bfcs_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (s3_valid_ff),
      .push_data (q_push_data),
      .pop       (q_pop),
      .valid     (rsp_valid),
      .head      (q_head),
      .count     (q_count)
   );

   assign rsp_filtered_pixel = q_head.filtered_pixel;
   assign rsp_centre_x       = q_head.centre_x;
   assign rsp_centre_y       = q_head.centre_y;

`ifndef NO_ASSERTIONS
   // credit scheme never lets the queue overrun
   assert property (@(posedge clock) disable iff (reset)
      (q_count + inflight) <= RSP_CW'(RSP_DEPTH))
      else $error("result queue over-committed");

   // a bypass is only taken when the previous cycle held an update
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_ff.fwd_cs || s1_ff.fwd_px)) |-> $past(s1_valid_ff))
      else $error("bypass without a preceding write-back");

   // raster column stays inside the image width
   assert property (@(posedge clock) disable iff (reset)
      IW_W'(col_ff) < w_eff)
      else $error("column position beyond image width");
`endif

endmodule

[tb/box_filter_column_sums_tb.sv]
`timescale 1ns / 100ps

module box_filter_column_sums_tb;
   import bfcs_pkg::*;

   // largest odd window the block can hold
   localparam int unsigned WINDOW_CAP    = ((MAX_WINDOW - 1) / 2) * 2 + 1;
   localparam int unsigned RANDOM_PIXELS = 230;
   // extra wait after the last owed result that covers the pipe
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned IDLE_PCT      = 33;
   // long response hold-off, started once enough results have gone by
   localparam int unsigned HOLD_CYCLES   = 200;
   localparam int unsigned HOLD_AFTER    = 60;
   localparam longint unsigned CYCLE_LIMIT = 200000;

   typedef enum logic {STEP_PIXEL, STEP_CSR} step_kind_type;

   // one row of the directed plan; typed rows carry a hand-written result
   typedef struct packed {
      step_kind_type     kind;
      logic [CSR_AW-1:0] index;
      logic [CSR_W-1:0]  value;
      logic              typed;
      rsp_type           want;
   } plan_row_type;

   localparam rsp_type NO_RSP = '0;

   localparam plan_row_type DIRECTED_PLAN [35] = '{
      // reset sizes (3x3 window, 640x480): first pixels sit on the border
      '{STEP_PIXEL, '0, 12'h000, 1'b0, NO_RSP},
      '{STEP_PIXEL, '0, 12'h0ff, 1'b0, NO_RSP},
      // 1x1 window on a 1x1 image: every pixel comes back as itself at (0,0)
      '{STEP_CSR, CSR_WINDOW_WIDTH,  12'd0, 1'b0, NO_RSP},
      '{STEP_CSR, CSR_WINDOW_HEIGHT, 12'd1, 1'b0, NO_RSP},
      '{STEP_CSR, CSR_IMAGE_WIDTH,   12'd1, 1'b0, NO_RSP},
      '{STEP_CSR, CSR_IMAGE_HEIGHT,  12'd1, 1'b0, NO_RSP},
      '{STEP_PIXEL, '0, 12'h000, 1'b1, '{8'h00, 10'd0, 12'd0}},
      '{STEP_PIXEL, '0, 12'h0ff, 1'b1, '{8'hff, 10'd0, 12'd0}},
      '{STEP_PIXEL, '0, 12'h055, 1'b1, '{8'h55, 10'd0, 12'd0}},
      '{STEP_PIXEL, '0, 12'h0aa, 1'b1, '{8'haa, 10'd0, 12'd0}},
      // zero image size is taken as one
      '{STEP_CSR, CSR_IMAGE_WIDTH,   12'd0, 1'b0, NO_RSP},
      '{STEP_CSR, CSR_IMAGE_HEIGHT,  12'd0, 1'b0, NO_RSP},
      '{STEP_PIXEL, '0, 12'h081, 1'b1, '{8'h81, 10'd0, 12'd0}},
      // oversize width clamps to the widest row, tallest frame
      '{STEP_CSR, CSR_IMAGE_WIDTH,   12'hfff, 1'b0, NO_RSP},
      '{STEP_CSR, CSR_IMAGE_HEIGHT,  12'd4095, 1'b0, NO_RSP},
      '{STEP_PIXEL, '0, 12'h012, 1'b1, '{8'h12, 10'd0, 12'd0}},
      '{STEP_PIXEL, '0, 12'h034, 1'b1, '{8'h34, 10'd1, 12'd0}},
      // 15x15 window over a 3x3 image never completes
      '{STEP_CSR, CSR_WINDOW_WIDTH,  12'd14, 1'b0, NO_RSP},
      '{STEP_CSR, CSR_WINDOW_HEIGHT, 12'd15, 1'b0, NO_RSP},
      '{STEP_CSR, CSR_IMAGE_WIDTH,   12'd3, 1'b0, NO_RSP},
      '{STEP_CSR, CSR_IMAGE_HEIGHT,  12'd3, 1'b0, NO_RSP},
      '{STEP_PIXEL, '0, 12'h0ff, 1'b0, NO_RSP},
      '{STEP_PIXEL, '0, 12'h0ff, 1'b0, NO_RSP},
      '{STEP_PIXEL, '0, 12'h0ff, 1'b0, NO_RSP},
      // even width rounds up to 3: one interior centre per 3x3 frame
      '{STEP_CSR, CSR_WINDOW_WIDTH,  12'd2, 1'b0, NO_RSP},
      '{STEP_CSR, CSR_WINDOW_HEIGHT, 12'd3, 1'b0, NO_RSP},
      '{STEP_PIXEL, '0, 12'h0ff, 1'b0, NO_RSP},
      '{STEP_PIXEL, '0, 12'h0ff, 1'b0, NO_RSP},
      '{STEP_PIXEL, '0, 12'h0ff, 1'b0, NO_RSP},
      '{STEP_PIXEL, '0, 12'h0ff, 1'b0, NO_RSP},
      '{STEP_PIXEL, '0, 12'h0ff, 1'b0, NO_RSP},
      '{STEP_PIXEL, '0, 12'h0ff, 1'b0, NO_RSP},
      '{STEP_PIXEL, '0, 12'h0ff, 1'b0, NO_RSP},
      '{STEP_PIXEL, '0, 12'h0ff, 1'b0, NO_RSP},
      '{STEP_PIXEL, '0, 12'h0ff, 1'b0, NO_RSP}
   };

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [PIX_W-1:0]   req_pixel = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [PIX_W-1:0]   rsp_filtered_pixel;
   logic [COL_W-1:0]   rsp_centre_x;
   logic [ROW_W-1:0]   rsp_centre_y;
   logic               csr_write_en = 1'b0;
   logic [CSR_AW-1:0]  csr_index = '0;
   logic [CSR_W-1:0]   csr_wdata = '0;

   // shadow of the filter state
   bit [PIX_W-1:0]     line_mem [MAX_WINDOW][MAX_WIDTH];
   int unsigned        col_sum [MAX_WIDTH];
   int unsigned        span_sum, recip_q, pos_x, pos_y;
   logic [WIN_W-1:0]   cfg_ww, cfg_wh;
   logic [IW_W-1:0]    cfg_iw;
   logic [IH_W-1:0]    cfg_ih;

   // window means still owed by the block, oldest first
   rsp_type            pending_means [$];
   int unsigned        mismatches = 0;
   int unsigned        results_seen = 0;
   longint unsigned    cycle_count = 0;
   // set for a run of phases where neither side idles
   bit                 burst = 1'b0;

   box_filter_column_sums u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pixel          (req_pixel),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_pixel (rsp_filtered_pixel),
      .rsp_centre_x       (rsp_centre_x),
      .rsp_centre_y       (rsp_centre_y),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // hard stop for a hung handshake
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // requested size to effective odd size, capped
   function automatic int unsigned odd_window(input logic [WIN_W-1:0] req);
      int unsigned s;
      s = (int'(req) / 2) * 2 + 1;
      return (s > WINDOW_CAP) ? WINDOW_CAP : s;
   endfunction

   // frame restart: position to the origin, fresh reciprocal
   function automatic void restart_scan();
      recip_q  = RECIP_ONE / (odd_window(cfg_ww) * odd_window(cfg_wh));
      pos_x    = 0;
      pos_y    = 0;
      span_sum = 0;
   endfunction

   function automatic void apply_reg(input logic [CSR_AW-1:0] idx,
                                     input logic [CSR_W-1:0] val);
      case (idx)
         CSR_WINDOW_WIDTH: begin
            cfg_ww = val[WIN_W-1:0];
         end
         CSR_WINDOW_HEIGHT: begin
            cfg_wh = val[WIN_W-1:0];
         end
         CSR_IMAGE_WIDTH: begin
            cfg_iw = val[IW_W-1:0];
         end
         CSR_IMAGE_HEIGHT: begin
            cfg_ih = val[IH_W-1:0];
         end
      endcase
      restart_scan();
   endfunction

   // advance the shadow by one pixel; returns 1 when a window mean is due
   function automatic bit box_mean(input logic [PIX_W-1:0] px, output rsp_type mean);
      int unsigned m, n, w, h, c, r, fresh, oldest;
      logic [63:0] prod;
      bit hit;
      m = odd_window(cfg_ww);
      n = odd_window(cfg_wh);
      w = (cfg_iw == 0) ? 1 : ((cfg_iw > MAX_WIDTH) ? MAX_WIDTH : cfg_iw);
      h = (cfg_ih == 0) ? 1 : cfg_ih;
      c = (pos_x >= w) ? w - 1 : pos_x;
      r = (pos_y >= h) ? h - 1 : pos_y;
      fresh  = r % MAX_WINDOW;
      oldest = (r + MAX_WINDOW - n) % MAX_WINDOW;

      // vertical: first row of a frame overwrites, later rows slide the column
      if (r == 0) begin
         col_sum[c] = px;
      end else begin
         col_sum[c] = col_sum[c] + px;
         if (r >= n) begin
            col_sum[c] = col_sum[c] - line_mem[oldest][c];
         end
      end
      line_mem[fresh][c] = px;

      // horizontal: slide across the column sums
      if (c == 0) begin
         span_sum = col_sum[0];
      end else begin
         span_sum = span_sum + col_sum[c];
         if (c >= m) begin
            span_sum = span_sum - col_sum[c - m];
         end
      end

      mean = '0;
      hit  = (r + 1 >= n) && (c + 1 >= m);
      if (hit) begin
         prod = 64'(span_sum) * 64'(recip_q);
         mean.filtered_pixel = PIX_W'(prod >> RECIP_SHIFT);
         mean.centre_x       = COL_W'(c - m / 2);
         mean.centre_y       = ROW_W'(r - n / 2);
      end

      // raster advance with wrap at frame end
      if (c + 1 >= w) begin
         pos_x = 0;
         pos_y = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         pos_x = c + 1;
         pos_y = r;
      end
      return hit;
   endfunction

   // offer one pixel, maybe after a gap; called and returns at a falling edge
   task automatic send_pixel(input logic [PIX_W-1:0] px, input logic typed,
                             input rsp_type want);
      rsp_type mean;
      bit hit;
      if (!burst && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do @(negedge clock); while (!burst && $urandom_range(0, 99) < IDLE_PCT);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (req_stall);
      // request taken at this edge
      hit = box_mean(px, mean);
      if (typed) begin
         pending_means.push_back(want);
      end else if (hit) begin
         pending_means.push_back(mean);
      end
      @(negedge clock);
   endtask

   // stop offering, wait for every owed mean, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_means.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // register write, only once the block has gone quiet
   task automatic write_reg(input logic [CSR_AW-1:0] idx, input logic [CSR_W-1:0] val);
      drain();
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      apply_reg(idx, val);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // response side: random stalls, one long hold-off, field checks
   initial begin : response_side
      int unsigned hold_left;
      bit hold_done;
      rsp_type want;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_means.size() == 0) begin
               $error("unexpected result: filtered_pixel %0d centre_x %0d centre_y %0d",
                      rsp_filtered_pixel, rsp_centre_x, rsp_centre_y);
               mismatches++;
            end else begin
               want = pending_means.pop_front();
               if (rsp_filtered_pixel !== want.filtered_pixel) begin
                  $error("filtered_pixel: expected %0d, got %0d",
                         want.filtered_pixel, rsp_filtered_pixel);
                  mismatches++;
               end
               if (rsp_centre_x !== want.centre_x) begin
                  $error("centre_x: expected %0d, got %0d", want.centre_x, rsp_centre_x);
                  mismatches++;
               end
               if (rsp_centre_y !== want.centre_y) begin
                  $error("centre_y: expected %0d, got %0d", want.centre_y, rsp_centre_y);
                  mismatches++;
               end
            end
         end
         @(negedge clock);
         // one long hold so the result queue fills and the input backs up
         if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !burst && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   // request side: directed plan, one full-width row, then random phases
   initial begin : request_side
      int unsigned phase, w_req, h_req, wsel, count, style, random_pixels;
      logic [CSR_W-1:0] wdata;
      logic [PIX_W-1:0] px;

      cfg_ww = WINDOW_RESET;
      cfg_wh = WINDOW_RESET;
      cfg_iw = IMAGE_WIDTH_RESET;
      cfg_ih = IMAGE_HEIGHT_RESET;
      restart_scan();
      random_pixels = 0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_PLAN[i]) begin
         if (DIRECTED_PLAN[i].kind == STEP_CSR) begin
            write_reg(DIRECTED_PLAN[i].index, DIRECTED_PLAN[i].value);
         end else begin
            send_pixel(DIRECTED_PLAN[i].value[PIX_W-1:0], DIRECTED_PLAN[i].typed,
                       DIRECTED_PLAN[i].want);
         end
      end

      // 3x1 window over the widest row, wrapping into the next row;
      // the response hold-off lands in here while pixels keep coming
      write_reg(CSR_WINDOW_WIDTH, 12'd2);
      write_reg(CSR_WINDOW_HEIGHT, 12'd0);
      write_reg(CSR_IMAGE_WIDTH, 12'd2047);
      write_reg(CSR_IMAGE_HEIGHT, 12'd2);
      repeat (MAX_WIDTH + 6) send_pixel(PIX_W'($urandom_range(0, 255)), 1'b0, NO_RSP);

      // random phases: new sizes each time, mostly small images and windows
      phase = 0;
      while (random_pixels < RANDOM_PIXELS) begin
         phase++;
         burst = (phase >= 2) && (phase < 6);

         w_req = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 6);
         h_req = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 6);
         wsel  = $urandom_range(0, 15);
         count = $urandom_range(15, 60);

         // upper data bits are junk for the window registers
         wdata = CSR_W'($urandom());
         wdata[WIN_W-1:0] = WIN_W'(w_req);
         write_reg(CSR_WINDOW_WIDTH, wdata);

         if (wsel == 0) begin
            wdata = '0;
         end else if (wsel == 1) begin
            // wide or masked width: short window so rows finish quickly
            wdata = CSR_W'($urandom_range(MAX_WIDTH, 4095));
            h_req = $urandom_range(0, 1);
            count = $urandom_range(15, 25);
         end else begin
            wdata = CSR_W'($urandom_range(1, 24));
         end
         write_reg(CSR_IMAGE_WIDTH, wdata);

         wdata = CSR_W'($urandom());
         wdata[WIN_W-1:0] = WIN_W'(h_req);
         write_reg(CSR_WINDOW_HEIGHT, wdata);

         if ($urandom_range(0, 15) == 0) begin
            wdata = '0;
         end else if ($urandom_range(0, 31) == 0) begin
            wdata = 12'd4095;
         end else begin
            wdata = CSR_W'($urandom_range(1, 12));
         end
         write_reg(CSR_IMAGE_HEIGHT, wdata);

         // pixel flavor: plain noise, saturated, or black/white
         style = $urandom_range(0, 3);
         repeat (count) begin
            case (style)
               2: begin
                  px = '1;
               end
               3: begin
                  px = $urandom_range(0, 1) ? '1 : '0;
               end
               default: begin
                  px = PIX_W'($urandom_range(0, 255));
               end
            endcase
            send_pixel(px, 1'b0, NO_RSP);
         end
         random_pixels += count;
      end
      burst = 1'b0;

      drain();
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/bfcs_pkg.sv
hw/rtl/bfcs_ram.sv
hw/rtl/bfcs_rsp_queue.sv
hw/rtl/box_filter_column_sums.sv
tb/box_filter_column_sums_tb.sv
